[src/gelu_pkg.sv]
`default_nettype none

package gelu_pkg;

  // Default sizes
  localparam int unsigned DefTanhEntries = 64;
  localparam int unsigned DefDataWidth   = 16;

  // Q.12 input format. The magnitude is clamped to 4.0, where tanh is already saturated.
  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned A_W       = 15;
  localparam int unsigned A_MAX     = 16384;

  // Internal widths of the inner-argument path
  localparam int unsigned SQ_W   = 29;
  localparam int unsigned CUBE_W = 31;
  localparam int unsigned W_W    = 26;
  localparam int unsigned U_W    = 27;
  localparam int unsigned T_W    = 17;
  localparam int unsigned S_W    = 18;
  localparam int unsigned FRAC_W = 26;

  // Q.24 coefficients
  localparam int unsigned CUBE_COEF    = 750193;
  localparam int unsigned SQRT2PI_COEF = 13386282;

  localparam int unsigned ONE_Q16 = 65536;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  // Shift-subtract quotient, evaluated at elaboration for table constants only.
  // The divisor stays below 2^63, so the partial remainder never overflows.
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One tanh table point in Q.16, from y = z/256 in Q.30: odd series, then eight
  // double-angle steps t <- 2t/(1+t^2). Used only to build constants.
  function automatic logic [T_W-1:0] tanh_point(longint unsigned y);
    longint unsigned y2;
    longint unsigned y3;
    longint unsigned y5;
    longint unsigned y7;
    longint unsigned t;
    longint unsigned den;
    y2 = (y * y) >> 30;
    y3 = (y2 * y) >> 30;
    y5 = (y3 * y2) >> 30;
    y7 = (y5 * y2) >> 30;
    t  = y - udiv64(y3, 64'd3) + udiv64(64'd2 * y5, 64'd15)
           - udiv64(64'd17 * y7, 64'd315);
    for (int d = 0; d < 8; d++) begin
      den = ONE_Q30 + ((t * t) >> 30);
      t   = udiv64(t << 31, den);
    end
    return T_W'((t + (64'd1 << 13)) >> 14);
  endfunction

endpackage

`default_nettype wire

[src/gelu_tanh_activation.sv]
`default_nettype none

// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+---------------------------
// input    | in        | in_valid_i / in_stall_o    | x_value_i  (signed Q.12)
// output   | out       | out_valid_o / out_stall_i  | y_value_o  (signed Q.12)
//
// Twelve register stages, one item per cycle while the output is not stalled. The
// stage count is set by the four multiplies of the inner argument, the table
// interpolation and the final x*(1+tanh) product.
// Reset clears only the valid bits. A stall while out_valid_o is high freezes the whole
// pipe and is passed to in_stall_o in the same cycle; bubbles do not block.
module gelu_tanh_activation
  import gelu_pkg::*;
#(
  parameter int unsigned TANH_ENTRIES = DefTanhEntries,
  parameter int unsigned DATA_WIDTH   = DefDataWidth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic signed [DATA_WIDTH-1:0] x_value_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic signed [DATA_WIDTH-1:0] y_value_o
);

  localparam int unsigned NUM_STAGES = 12;
  localparam int unsigned MW  = (DATA_WIDTH > A_W + 1) ? DATA_WIDTH : A_W + 1;
  localparam int unsigned IW  = $clog2(TANH_ENTRIES);
  localparam int unsigned TW  = $clog2(TANH_ENTRIES + 1);
  localparam int unsigned PNW = FRAC_W + IW;
  localparam int unsigned PW  = DATA_WIDTH + S_W + 1;

  // Constant tanh table, points 0..N over [0,4]
  logic [T_W-1:0] tanh_tab [TANH_ENTRIES+1];

  for (genvar k = 0; k <= TANH_ENTRIES; k++) begin : g_tab
    localparam longint unsigned YK =
      ((64'(k) << 25) + 64'(TANH_ENTRIES)) / (64'(2 * TANH_ENTRIES));
    localparam logic [T_W-1:0] TK = tanh_point(YK);
    assign tanh_tab[k] = TK;
  end

  logic [NUM_STAGES-1:0] vld_q;
  logic                  advance;

  assign advance     = !(vld_q[NUM_STAGES-1] && out_stall_i);
  assign in_stall_o  = !advance;
  assign out_valid_o = vld_q[NUM_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[NUM_STAGES-2:0], in_valid_i};
    end
  end

  // Stage 1: clamped magnitude
  logic [DATA_WIDTH-1:0] x_mag;
  logic [MW-1:0]         x_mag_ext;
  logic [A_W-1:0]        a_d;

  assign x_mag     = x_value_i[DATA_WIDTH-1] ? DATA_WIDTH'(~x_value_i + 1'b1)
                                             : DATA_WIDTH'(x_value_i);
  assign x_mag_ext = MW'(x_mag);
  assign a_d       = (x_mag_ext >= MW'(A_MAX)) ? A_W'(A_MAX) : A_W'(x_mag_ext);

  // Stage 2: square
  logic [2*A_W-1:0] sq_full;
  // Stage 3: cube in Q.24
  logic [SQ_W+A_W-1:0] cube_full;
  // Stage 4: 0.044715 * cube
  logic [50:0] w_full;
  // Stage 6: sqrt(2/pi) * u
  logic [51:0] v_full;
  // Stage 7: table position
  logic [PNW-1:0] pos_full;
  // Stage 8: table read
  logic [TW-1:0] idx_lo;
  logic [TW-1:0] idx_hi;
  logic signed [S_W-1:0] diff_d;
  // Stage 9: interpolation
  logic signed [44:0] interp_prod;
  logic signed [44:0] interp_sum;
  logic [T_W-1:0]     t_d;
  // Stage 11: final product with rounding offset
  logic signed [PW-1:0] prod_d;

  logic signed [DATA_WIDTH-1:0] x1_q, x2_q, x3_q, x4_q, x5_q, x6_q, x7_q, x8_q, x9_q, x10_q;
  logic [A_W-1:0]     a1_q, a2_q, a3_q, a4_q;
  logic [SQ_W-1:0]    sq2_q;
  logic [CUBE_W-1:0]  cube3_q;
  logic [W_W-1:0]     w4_q;
  logic [U_W-1:0]     u5_q;
  logic [U_W-1:0]     v6_q;
  logic               sat7_q, sat8_q;
  logic [IW-1:0]      idx7_q;
  logic [FRAC_W-1:0]  frac7_q, frac8_q;
  logic [T_W-1:0]     base8_q;
  logic signed [S_W-1:0] diff8_q;
  logic [T_W-1:0]     t9_q;
  logic [S_W-1:0]     s10_q;
  logic signed [PW-1:0] prod11_q;
  logic signed [DATA_WIDTH-1:0] y_q;

  assign sq_full   = a1_q * a1_q;
  assign cube_full = sq2_q * a2_q;
  assign w_full    = cube3_q * 20'(CUBE_COEF) + 51'(64'd1 << 23);
  assign v_full    = u5_q * 24'(SQRT2PI_COEF) + 52'(64'd1 << 23);
  assign pos_full  = v6_q[FRAC_W-1:0] * PNW'(TANH_ENTRIES);

  assign idx_lo = TW'(idx7_q);
  assign idx_hi = TW'(idx_lo + 1'b1);
  assign diff_d = $signed({1'b0, tanh_tab[idx_hi]}) - $signed({1'b0, tanh_tab[idx_lo]});

  // T[i]*(1-f) + T[i+1]*f rewritten as T[i] + (T[i+1]-T[i])*f
  assign interp_prod = diff8_q * $signed({1'b0, frac8_q});
  assign interp_sum  = $signed({2'b00, base8_q, {FRAC_W{1'b0}}}) + interp_prod
                     + 45'sd33554432;
  assign t_d         = interp_sum[42:26];

  assign prod_d = x10_q * $signed({1'b0, s10_q}) + $signed(PW'(ONE_Q16));

  always_ff @(posedge clk_i) begin
    if (advance) begin
      x1_q    <= x_value_i;
      a1_q    <= a_d;

      x2_q    <= x1_q;
      a2_q    <= a1_q;
      sq2_q   <= sq_full[SQ_W-1:0];

      x3_q    <= x2_q;
      a3_q    <= a2_q;
      cube3_q <= cube_full[42:12];

      x4_q    <= x3_q;
      a4_q    <= a3_q;
      w4_q    <= w_full[49:24];

      x5_q    <= x4_q;
      u5_q    <= {a4_q, {FRAC_BITS{1'b0}}} + U_W'(w4_q);

      x6_q    <= x5_q;
      v6_q    <= v_full[50:24];

      // v >= 4.0 in Q.24 saturates tanh
      x7_q    <= x6_q;
      sat7_q  <= v6_q[U_W-1];
      idx7_q  <= pos_full[PNW-1:FRAC_W];
      frac7_q <= pos_full[FRAC_W-1:0];

      x8_q    <= x7_q;
      sat8_q  <= sat7_q;
      base8_q <= tanh_tab[idx_lo];
      diff8_q <= diff_d;
      frac8_q <= frac7_q;

      x9_q    <= x8_q;
      t9_q    <= sat8_q ? T_W'(ONE_Q16) : t_d;

      // 1 + tanh, tanh odd in x
      x10_q   <= x9_q;
      s10_q   <= x9_q[DATA_WIDTH-1] ? S_W'(ONE_Q16) - S_W'(t9_q)
                                    : S_W'(ONE_Q16) + S_W'(t9_q);

      prod11_q <= prod_d;

      // floor division by 2^17; |y| <= |x| so no saturation is needed
      y_q     <= prod11_q[DATA_WIDTH+16:17];
    end
  end

  assign y_value_o = y_q;

endmodule

`default_nettype wire

[verif/tb_gelu_tanh_activation.sv]
`timescale 1ns / 1ps

module tb_gelu_tanh_activation;

  localparam int unsigned DW     = gelu_pkg::DefDataWidth;
  localparam int unsigned TANH_N = gelu_pkg::DefTanhEntries;
  localparam int unsigned FRAC   = gelu_pkg::FRAC_BITS;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 24;
  localparam int unsigned QUIET_TAIL  = 120;
  localparam int unsigned N_RANDOM    = 1150;

  typedef logic signed [DW-1:0] q12_t;

  typedef struct {
    q12_t x;
    bit   drain_first;
  } x_item_t;

  typedef struct {
    q12_t x;
    q12_t y;
  } gelu_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  q12_t x_value = '0;
  logic out_stall = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  q12_t y_value_o;

  x_item_t    pending_x[$];
  gelu_pair_t gelu_expected[$];
  longint unsigned tanh_q16[0:TANH_N];

  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned mode_cnt = 0;
  int unsigned stuck_cycles = 0;
  int unsigned mismatches = 0;
  bit tx_noisy = 1'b1;
  bit rx_noisy = 1'b1;

  gelu_tanh_activation dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .x_value_i  (x_value),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .y_value_o  (y_value_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // tanh(4k/N) in Q.16: odd series at z/256 in Q.30, then eight doublings
  function automatic longint unsigned tanh_table_point(int unsigned k);
    longint unsigned z;
    longint unsigned z2;
    longint unsigned z3;
    longint unsigned z5;
    longint unsigned z7;
    longint unsigned th;
    longint unsigned den;
    z  = ((64'(k) << 25) + 64'(TANH_N)) / (64'd2 * 64'(TANH_N));
    z2 = (z * z) >> 30;
    z3 = (z2 * z) >> 30;
    z5 = (z3 * z2) >> 30;
    z7 = (z5 * z2) >> 30;
    th = z - z3 / 64'd3 + (64'd2 * z5) / 64'd15 - (64'd17 * z7) / 64'd315;
    for (int i = 0; i < 8; i++) begin
      den = (64'd1 << 30) + ((th * th) >> 30);
      th  = (th << 31) / den;
    end
    return (th + (64'd1 << 13)) >> 14;
  endfunction

  function automatic q12_t gelu_of(q12_t x);
    longint          xs;
    longint unsigned mag;
    longint unsigned cube;
    longint unsigned corr;
    longint unsigned inner;
    longint unsigned arg;
    longint unsigned prod;
    longint unsigned frac;
    longint unsigned th;
    longint unsigned idx;
    longint          one_plus;
    longint          num;
    longint          y;
    longint          y_max;
    xs = x;
    mag = (xs < 0) ? -xs : xs;
    if (mag > (64'd4 << FRAC)) mag = 64'd4 << FRAC;
    cube  = (mag * mag * mag) >> 12;
    corr  = (cube * 64'(gelu_pkg::CUBE_COEF) + (64'd1 << 23)) >> 24;
    inner = (mag << 12) + corr;
    arg   = (inner * 64'(gelu_pkg::SQRT2PI_COEF) + (64'd1 << 23)) >> 24;
    th = 64'(gelu_pkg::ONE_Q16);
    if (arg < (64'd4 << 24)) begin
      prod = arg * 64'(TANH_N);
      idx  = prod >> 26;
      frac = prod & ((64'd1 << 26) - 1);
      if (idx < TANH_N)
        th = (tanh_q16[idx] * ((64'd1 << 26) - frac) + tanh_q16[idx + 1] * frac
              + (64'd1 << 25)) >> 26;
    end
    one_plus = (xs < 0) ? longint'(gelu_pkg::ONE_Q16) - longint'(th)
                        : longint'(gelu_pkg::ONE_Q16) + longint'(th);
    num = xs * one_plus + (64'sd1 <<< 16);
    y = num >>> 17;   // floor, so ties go toward +inf
    y_max = (64'sd1 <<< (DW - 1)) - 1;
    if (y > y_max) y = y_max;
    if (y < -y_max - 1) y = -y_max - 1;
    return q12_t'(y);
  endfunction

  // random mode changes so some stretches run with no idling at all
  always @(posedge clk_i) begin
    mode_cnt <= mode_cnt + 1;
    if (mode_cnt % 256 == 255) begin
      tx_noisy <= ($urandom_range(0, 3) != 0);
      rx_noisy <= ($urandom_range(0, 3) != 0);
    end
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      x_value  <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall_o)
        gelu_expected.push_back('{x: x_value, y: gelu_of(x_value)});
      if (!in_valid || !in_stall_o) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_x.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_x[0].drain_first && gelu_expected.size() != 0) begin
          in_valid <= 1'b0;
        end else if (tx_noisy && pending_x.size() > QUIET_TAIL
                     && $urandom_range(0, 4) == 0) begin
          in_valid <= 1'b0;
          send_gap <= $urandom_range(0, 12);
        end else begin
          in_valid <= 1'b1;
          x_value  <= pending_x[0].x;
          void'(pending_x.pop_front());
        end
      end
    end
  end

  // receiver stall bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rx_noisy && pending_x.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    gelu_pair_t oldest;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (gelu_expected.size() == 0) begin
        $display("%0t: y_value %0d with no item pending", $time, y_value_o);
        mismatches++;
      end else begin
        oldest = gelu_expected.pop_front();
        if (y_value_o !== oldest.y) begin
          $display("%0t: x_value %0d: y_value expected %0d actual %0d",
                   $time, oldest.x, oldest.y, y_value_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    q12_t directed[$];
    q12_t xr;
    for (int k = 0; k <= TANH_N; k++) tanh_q16[k] = tanh_table_point(k);

    // zero, +-1 lsb, full-scale ends, clamp edge at 4.0, tanh saturation knee,
    // alternating bit patterns
    directed = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768,
                 16'sd16384, -16'sd16384, 16'sd16383, -16'sd16383,
                 16'sd16385, -16'sd16385, 16'sd4096, -16'sd4096,
                 16'sd2048, -16'sd2048, 16'sd8192, -16'sd8192,
                 16'sd13900, -16'sd13900, 16'sd12000, -16'sd12000,
                 16'sd21845, -16'sd21846, 16'sd3, -16'sd3};
    foreach (directed[i]) pending_x.push_back('{x: directed[i], drain_first: 1'b0});

    for (int n = 0; n < N_RANDOM; n++) begin
      case ($urandom_range(0, 9))
        0, 1:    xr = q12_t'($urandom_range(0, 65535));
        2, 3:    xr = q12_t'(int'($urandom_range(0, 1024)) - 512);
        default: xr = q12_t'(int'($urandom_range(0, 34000)) - 17000);
      endcase
      // pipe runs dry before the random part and once in the middle
      pending_x.push_back('{x: xr, drain_first: (n == 0 || n == N_RANDOM / 2)});
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_x.size() != 0 || in_valid) @(posedge clk_i);
    while (gelu_expected.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (gelu_expected.size() != 0) begin
      $display("%0t: %0d items with no y_value", $time, gelu_expected.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
